>>> src/accalu_pkg.sv
// Shared types and helpers for the accumulator ALU.
// Holds the operation codes, the flag group and the parity function.
// No dependencies.
`timescale 1ns / 1ps

package accalu_pkg;

    localparam int DataW = 8;
    localparam int WideW = 16;
    localparam int OpW   = 4;

    typedef enum logic [OpW-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_AND = 4'd2,
        OP_XOR = 4'd3,
        OP_OR  = 4'd4,
        OP_CMP = 4'd5,
        OP_INC = 4'd6,
        OP_DEC = 4'd7,
        OP_RLC = 4'd8,
        OP_RRC = 4'd9,
        OP_RAL = 4'd10,
        OP_RAR = 4'd11,
        OP_CMA = 4'd12,
        OP_STC = 4'd13,
        OP_DAA = 4'd14,
        OP_DAD = 4'd15
    } op_t;

    typedef struct packed {
        logic carry;
        logic aux;
        logic zero;
        logic sign;
        logic parity;
    } flags_t;

    localparam logic [3:0] NibbleMax = 4'd9;
    localparam logic [DataW-1:0] DaaLowCorr  = 8'h06;
    localparam logic [DataW-1:0] DaaHighCorr = 8'h60;

    function automatic logic even_parity(input logic [DataW-1:0] v);
        even_parity = ~(^v);
    endfunction

endpackage

>>> src/accalu_core.sv
// Combinational datapath of the accumulator ALU: one operation per beat.
// Computes the result byte, the double-add sum and the new flags.
// Depends on accalu_pkg.
`timescale 1ns / 1ps

module accalu_core (
    input  logic [3:0]             op,
    input  logic [7:0]             acc,
    input  logic [7:0]             operand,
    input  logic [15:0]            pair_hl,
    input  logic [15:0]            pair_other,
    input  accalu_pkg::flags_t     flags_in,
    output logic [7:0]             result,
    output logic [15:0]            wide_result,
    output accalu_pkg::flags_t     flags_out
);

    logic [8:0]  add_sum;
    logic [4:0]  add_nib;
    logic [7:0]  nb;
    logic [8:0]  sub_sum;
    logic [4:0]  sub_nib;
    logic [3:0]  lo;
    logic [3:0]  hi;
    logic        lo_big;
    logic        daa_high;
    logic [7:0]  corr;
    logic [4:0]  daa_nib;
    logic [16:0] dad_sum;
    logic [7:0]  szp_byte;
    logic        szp_en;

    always_comb
    begin
        add_sum  = {1'b0, acc} + {1'b0, operand};
        add_nib  = {1'b0, acc[3:0]} + {1'b0, operand[3:0]};
        nb       = ~operand;
        sub_sum  = {1'b0, acc} + {1'b0, nb} + 9'd1;
        sub_nib  = {1'b0, acc[3:0]} + {1'b0, nb[3:0]} + 5'd1;
        lo       = acc[3:0];
        hi       = acc[7:4];
        lo_big   = (lo > accalu_pkg::NibbleMax);
        daa_high = (hi > accalu_pkg::NibbleMax) || flags_in.carry
                   || ((hi >= accalu_pkg::NibbleMax) && lo_big);
        corr     = ((lo_big || flags_in.aux) ? accalu_pkg::DaaLowCorr : 8'h00)
                   | (daa_high ? accalu_pkg::DaaHighCorr : 8'h00);
        daa_nib  = {1'b0, lo} + {1'b0, corr[3:0]};
        dad_sum  = {1'b0, pair_hl} + {1'b0, pair_other};
    end

    always_comb
    begin
        result      = acc;
        wide_result = pair_hl;
        flags_out   = flags_in;
        szp_byte    = acc;
        szp_en      = 1'b1;
        case (accalu_pkg::op_t'(op))
            accalu_pkg::OP_ADD:
            begin
                result          = add_sum[7:0];
                flags_out.carry = add_sum[8];
                flags_out.aux   = add_nib[4];
                szp_byte        = add_sum[7:0];
            end
            accalu_pkg::OP_SUB:
            begin
                result          = sub_sum[7:0];
                flags_out.carry = ~sub_sum[8];
                flags_out.aux   = sub_nib[4];
                szp_byte        = sub_sum[7:0];
            end
            accalu_pkg::OP_CMP:
            begin
                flags_out.carry = ~sub_sum[8];
                flags_out.aux   = sub_nib[4];
                szp_byte        = sub_sum[7:0];
            end
            accalu_pkg::OP_AND:
            begin
                result          = acc & operand;
                flags_out.carry = 1'b0;
                flags_out.aux   = 1'b0;
                szp_byte        = acc & operand;
            end
            accalu_pkg::OP_XOR:
            begin
                result          = acc ^ operand;
                flags_out.carry = 1'b0;
                flags_out.aux   = 1'b0;
                szp_byte        = acc ^ operand;
            end
            accalu_pkg::OP_OR:
            begin
                result          = acc | operand;
                flags_out.carry = 1'b0;
                flags_out.aux   = 1'b0;
                szp_byte        = acc | operand;
            end
            accalu_pkg::OP_INC:
            begin
                result        = operand + 8'd1;
                flags_out.aux = (operand[3:0] == 4'hF);
                szp_byte      = operand + 8'd1;
            end
            accalu_pkg::OP_DEC:
            begin
                result        = operand - 8'd1;
                flags_out.aux = (operand[3:0] != 4'h0);
                szp_byte      = operand - 8'd1;
            end
            accalu_pkg::OP_RLC:
            begin
                result          = {acc[6:0], acc[7]};
                flags_out.carry = acc[7];
                szp_en          = 1'b0;
            end
            accalu_pkg::OP_RRC:
            begin
                result          = {acc[0], acc[7:1]};
                flags_out.carry = acc[0];
                szp_en          = 1'b0;
            end
            accalu_pkg::OP_RAL:
            begin
                result          = {acc[6:0], flags_in.carry};
                flags_out.carry = acc[7];
                szp_en          = 1'b0;
            end
            accalu_pkg::OP_RAR:
            begin
                result          = {flags_in.carry, acc[7:1]};
                flags_out.carry = acc[0];
                szp_en          = 1'b0;
            end
            accalu_pkg::OP_CMA:
            begin
                result = ~acc;
                szp_en = 1'b0;
            end
            accalu_pkg::OP_STC:
            begin
                flags_out.carry = 1'b1;
                szp_en          = 1'b0;
            end
            accalu_pkg::OP_DAA:
            begin
                result          = acc + corr;
                flags_out.carry = flags_in.carry | daa_high;
                flags_out.aux   = daa_nib[4];
                szp_byte        = acc + corr;
            end
            accalu_pkg::OP_DAD:
            begin
                wide_result     = dad_sum[15:0];
                flags_out.carry = dad_sum[16];
                szp_en          = 1'b0;
            end
            default:
            begin
                szp_en = 1'b0;
            end
        endcase
        if (szp_en)
        begin
            flags_out.zero   = (szp_byte == 8'h00);
            flags_out.sign   = szp_byte[7];
            flags_out.parity = accalu_pkg::even_parity(szp_byte);
        end
    end

endmodule

>>> src/accumulator_alu_with_flags.sv
// Top level of the accumulator ALU: input register, datapath, result register.
// Depends on accalu_pkg and accalu_core.
`timescale 1ns / 1ps

// A command is taken at every clock edge where start is high; busy is always
// low, so one operation enters per cycle. Each command passes through the input
// register and then the result register, with the combinational ALU logic between
// them; its result sits on the result ports with done high for exactly one cycle,
// in command order. The receiver cannot stall, and none is needed since the
// pipeline never holds results back.
module accumulator_alu_with_flags (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  op,
    input  logic [7:0]  acc,
    input  logic [7:0]  operand,
    input  logic [15:0] pair_hl,
    input  logic [15:0] pair_other,
    input  logic        carry_in,
    input  logic        aux_in,
    input  logic        zero_in,
    input  logic        sign_in,
    input  logic        parity_in,
    output logic        done,
    output logic [7:0]  result,
    output logic [15:0] wide_result,
    output logic        carry_out,
    output logic        aux_out,
    output logic        zero_out,
    output logic        sign_out,
    output logic        parity_out
);

    logic               in_valid_reg;
    logic [3:0]         op_reg;
    logic [7:0]         acc_reg;
    logic [7:0]         operand_reg;
    logic [15:0]        hl_reg;
    logic [15:0]        other_reg;
    accalu_pkg::flags_t flags_in_reg;

    logic               out_valid_reg;
    logic [7:0]         result_reg;
    logic [15:0]        wide_reg;
    accalu_pkg::flags_t flags_out_reg;

    logic [7:0]         result_next;
    logic [15:0]        wide_next;
    accalu_pkg::flags_t flags_next;
    logic               accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= accept;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op;
            acc_reg      <= acc;
            operand_reg  <= operand;
            hl_reg       <= pair_hl;
            other_reg    <= pair_other;
            flags_in_reg <= '{carry: carry_in, aux: aux_in, zero: zero_in,
                              sign: sign_in, parity: parity_in};
        end
        if (in_valid_reg)
        begin
            result_reg    <= result_next;
            wide_reg      <= wide_next;
            flags_out_reg <= flags_next;
        end
    end

    accalu_core u_core (
        .op          (op_reg),
        .acc         (acc_reg),
        .operand     (operand_reg),
        .pair_hl     (hl_reg),
        .pair_other  (other_reg),
        .flags_in    (flags_in_reg),
        .result      (result_next),
        .wide_result (wide_next),
        .flags_out   (flags_next)
    );

    assign done        = out_valid_reg;
    assign result      = result_reg;
    assign wide_result = wide_reg;
    assign carry_out   = flags_out_reg.carry;
    assign aux_out     = flags_out_reg.aux;
    assign zero_out    = flags_out_reg.zero;
    assign sign_out    = flags_out_reg.sign;
    assign parity_out  = flags_out_reg.parity;

`ifndef NO_ASSERTIONS
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("command did not produce a result two cycles later");

    a_done_has_command: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result strobe without a matching command");

    a_wide_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(op, 2) != accalu_pkg::OP_DAD) |-> wide_result == $past(pair_hl, 2))
        else $error("wide result changed by a byte operation");

    a_dad_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(op, 2) == accalu_pkg::OP_DAD)
        |-> (result == $past(acc, 2) && zero_out == $past(zero_in, 2)))
        else $error("double add disturbed accumulator or zero flag");
`endif

endmodule

>>> test/accalu_scoreboard_pkg.sv
// Command and result records plus a scoreboard for the accumulator ALU test.
// Predicts every accepted command and checks the results in command order.
// Depends on accalu_pkg.
`timescale 1ns / 1ps

package accalu_scoreboard_pkg;

    import accalu_pkg::*;

    typedef struct packed {
        op_t         op;
        logic [7:0]  acc;
        logic [7:0]  operand;
        logic [15:0] hl;
        logic [15:0] other;
        flags_t      flags;
    } alu_cmd_t;

    typedef struct packed {
        logic [7:0]  result;
        logic [15:0] wide;
        flags_t      flags;
    } alu_res_t;

    class alu_scoreboard;

        alu_res_t    pending_results[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function alu_res_t alu_outcome(alu_cmd_t c);
            alu_res_t   r;
            logic [8:0]  sum;
            logic [16:0] wsum;
            logic [4:0]  nib;
            logic [7:0]  nb;
            logic [7:0]  corr;
            logic [7:0]  szp_byte;
            logic [3:0]  lo;
            logic [3:0]  hi;
            bit          szp;

            r.result = c.acc;
            r.wide   = c.hl;
            r.flags  = c.flags;
            szp      = 1'b1;
            szp_byte = '0;
            case (c.op)
                OP_ADD:
                begin
                    sum = {1'b0, c.acc} + {1'b0, c.operand};
                    nib = {1'b0, c.acc[3:0]} + {1'b0, c.operand[3:0]};
                    r.result = sum[7:0];
                    r.flags.carry = sum[8];
                    r.flags.aux = nib[4];
                    szp_byte = sum[7:0];
                end
                OP_SUB, OP_CMP:
                begin
                    nb  = ~c.operand;
                    sum = {1'b0, c.acc} + {1'b0, nb} + 9'd1;
                    nib = {1'b0, c.acc[3:0]} + {1'b0, nb[3:0]} + 5'd1;
                    r.flags.carry = (c.acc < c.operand);
                    r.flags.aux = nib[4];
                    szp_byte = sum[7:0];
                    if (c.op == OP_SUB)
                    begin
                        r.result = sum[7:0];
                    end
                end
                OP_AND, OP_XOR, OP_OR:
                begin
                    if (c.op == OP_AND)
                    begin
                        r.result = c.acc & c.operand;
                    end
                    else if (c.op == OP_XOR)
                    begin
                        r.result = c.acc ^ c.operand;
                    end
                    else
                    begin
                        r.result = c.acc | c.operand;
                    end
                    r.flags.carry = 1'b0;
                    r.flags.aux = 1'b0;
                    szp_byte = r.result;
                end
                OP_INC:
                begin
                    r.result = c.operand + 8'd1;
                    r.flags.aux = (c.operand[3:0] == 4'hF);
                    szp_byte = r.result;
                end
                OP_DEC:
                begin
                    r.result = c.operand - 8'd1;
                    r.flags.aux = (c.operand[3:0] != 4'h0);
                    szp_byte = r.result;
                end
                OP_RLC:
                begin
                    r.result = {c.acc[6:0], c.acc[7]};
                    r.flags.carry = c.acc[7];
                    szp = 1'b0;
                end
                OP_RRC:
                begin
                    r.result = {c.acc[0], c.acc[7:1]};
                    r.flags.carry = c.acc[0];
                    szp = 1'b0;
                end
                OP_RAL:
                begin
                    r.result = {c.acc[6:0], c.flags.carry};
                    r.flags.carry = c.acc[7];
                    szp = 1'b0;
                end
                OP_RAR:
                begin
                    r.result = {c.flags.carry, c.acc[7:1]};
                    r.flags.carry = c.acc[0];
                    szp = 1'b0;
                end
                OP_CMA:
                begin
                    r.result = ~c.acc;
                    szp = 1'b0;
                end
                OP_STC:
                begin
                    r.flags.carry = 1'b1;
                    szp = 1'b0;
                end
                OP_DAA:
                begin
                    lo   = c.acc[3:0];
                    hi   = c.acc[7:4];
                    corr = '0;
                    if (lo > NibbleMax || c.flags.aux)
                    begin
                        corr = corr | DaaLowCorr;
                    end
                    if (hi > NibbleMax || c.flags.carry || (hi >= NibbleMax && lo > NibbleMax))
                    begin
                        corr = corr | DaaHighCorr;
                        r.flags.carry = 1'b1;
                    end
                    nib = {1'b0, lo} + {1'b0, corr[3:0]};
                    r.result = c.acc + corr;
                    r.flags.aux = nib[4];
                    szp_byte = r.result;
                end
                default:
                begin
                    wsum = {1'b0, c.hl} + {1'b0, c.other};
                    r.wide = wsum[15:0];
                    r.flags.carry = wsum[16];
                    szp = 1'b0;
                end
            endcase
            if (szp)
            begin
                r.flags.zero   = (szp_byte == 8'h00);
                r.flags.sign   = szp_byte[7];
                r.flags.parity = ~(^szp_byte);
            end
            return r;
        endfunction

        function void note_command(alu_cmd_t c);
            pending_results.push_back(alu_outcome(c));
        endfunction

        function void report(string what);
            if (mismatches < 10)
            begin
                $display("%0t: %s", $realtime, what);
            end
            mismatches++;
        endfunction

        function void check_result(alu_res_t got);
            alu_res_t want;

            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected beat result=%02h wide=%04h flags(cazsp)=%05b",
                                 got.result, got.wide, got.flags));
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
            begin
                report($sformatf({"mismatch: expected result=%02h wide=%04h flags(cazsp)=%05b,",
                                  " got result=%02h wide=%04h flags(cazsp)=%05b"},
                                 want.result, want.wide, want.flags,
                                 got.result, got.wide, got.flags));
            end
        endfunction

    endclass

endpackage

>>> test/accumulator_alu_with_flags_test.sv
// Self-checking test of accumulator_alu_with_flags: directed corner cases,
// then random commands with idle bursts, checked against a scoreboard.
// Depends on accalu_pkg and accalu_scoreboard_pkg.
`timescale 1ns / 1ps

module accumulator_alu_with_flags_test;

    import accalu_pkg::*;
    import accalu_scoreboard_pkg::*;

    localparam int RandItems  = 1400;
    localparam int QuietTail  = 200;
    localparam int CycleLimit = 200000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    alu_cmd_t    cmd;
    logic        done;
    logic [7:0]  result;
    logic [15:0] wide_result;
    logic        carry_out;
    logic        aux_out;
    logic        zero_out;
    logic        sign_out;
    logic        parity_out;
    int unsigned cycles = 0;

    alu_scoreboard sb = new();

    accumulator_alu_with_flags i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (cmd.op),
        .acc        (cmd.acc),
        .operand    (cmd.operand),
        .pair_hl    (cmd.hl),
        .pair_other (cmd.other),
        .carry_in   (cmd.flags.carry),
        .aux_in     (cmd.flags.aux),
        .zero_in    (cmd.flags.zero),
        .sign_in    (cmd.flags.sign),
        .parity_in  (cmd.flags.parity),
        .done       (done),
        .result     (result),
        .wide_result(wide_result),
        .carry_out  (carry_out),
        .aux_out    (aux_out),
        .zero_out   (zero_out),
        .sign_out   (sign_out),
        .parity_out (parity_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin : watch_ports
        alu_res_t got;

        if (rst_n)
        begin
            if (done)
            begin
                got.result = result;
                got.wide   = wide_result;
                got.flags  = '{carry_out, aux_out, zero_out, sign_out, parity_out};
                sb.check_result(got);
            end
            if (start && !busy)
            begin
                sb.note_command(cmd);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic alu_cmd_t cmd_of(op_t op, logic [7:0] a, logic [7:0] b,
                                        logic [15:0] hl, logic [15:0] other,
                                        logic [4:0] flags);
        alu_cmd_t c;

        c.op      = op;
        c.acc     = a;
        c.operand = b;
        c.hl      = hl;
        c.other   = other;
        c.flags   = flags_t'(flags);
        return c;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return {4'h9, 4'($urandom_range(0, 15))};
            3: return {4'($urandom_range(0, 15)), 4'hF};
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_pair();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic alu_cmd_t random_cmd();
        return cmd_of(op_t'($urandom_range(0, 15)), pick_byte(), pick_byte(),
                      pick_pair(), pick_pair(), 5'($urandom_range(0, 31)));
    endfunction

    task automatic send_beat(input alu_cmd_t c);
        @(negedge clk);
        cmd   <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
            cmd   <= random_cmd();
        end
    endtask

    task automatic wait_results();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin : run
        bit idle_on;

        clk    = 1'b0;
        rst_n  = 1'b0;
        start  = 1'b0;
        cmd    = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // directed corners, every operation
        send_beat(cmd_of(OP_ADD, 8'hFF, 8'h01, 16'h0000, 16'h0000, 5'b00000));
        send_beat(cmd_of(OP_ADD, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF, 5'b11111));
        send_beat(cmd_of(OP_ADD, 8'h0F, 8'h01, 16'h1234, 16'h0000, 5'b00000));
        send_beat(cmd_of(OP_SUB, 8'h00, 8'h01, 16'h0000, 16'h0000, 5'b00000));
        send_beat(cmd_of(OP_SUB, 8'h55, 8'h55, 16'h0000, 16'h0000, 5'b10000));
        send_beat(cmd_of(OP_AND, 8'hFF, 8'h80, 16'h0000, 16'h0000, 5'b11000));
        send_beat(cmd_of(OP_XOR, 8'hFF, 8'hFF, 16'h0000, 16'h0000, 5'b11000));
        send_beat(cmd_of(OP_OR, 8'h00, 8'h00, 16'h0000, 16'h0000, 5'b11000));
        send_beat(cmd_of(OP_CMP, 8'h10, 8'h20, 16'h0000, 16'h0000, 5'b00000));
        send_beat(cmd_of(OP_CMP, 8'hFF, 8'hFF, 16'h0000, 16'h0000, 5'b00000));
        send_beat(cmd_of(OP_INC, 8'h00, 8'hFF, 16'h0000, 16'h0000, 5'b10000));
        send_beat(cmd_of(OP_INC, 8'h00, 8'h0F, 16'h0000, 16'h0000, 5'b00000));
        send_beat(cmd_of(OP_DEC, 8'h00, 8'h00, 16'h0000, 16'h0000, 5'b10000));
        send_beat(cmd_of(OP_DEC, 8'h00, 8'h10, 16'h0000, 16'h0000, 5'b00000));
        send_beat(cmd_of(OP_RLC, 8'h80, 8'h00, 16'h0000, 16'h0000, 5'b01111));
        send_beat(cmd_of(OP_RRC, 8'h01, 8'h00, 16'h0000, 16'h0000, 5'b00000));
        send_beat(cmd_of(OP_RAL, 8'h80, 8'h00, 16'h0000, 16'h0000, 5'b10000));
        send_beat(cmd_of(OP_RAR, 8'h01, 8'h00, 16'h0000, 16'h0000, 5'b00000));
        send_beat(cmd_of(OP_CMA, 8'h00, 8'hFF, 16'h0000, 16'h0000, 5'b11111));
        send_beat(cmd_of(OP_STC, 8'hA5, 8'h00, 16'h0000, 16'h0000, 5'b00000));
        send_beat(cmd_of(OP_DAA, 8'h9A, 8'h00, 16'h0000, 16'h0000, 5'b00000));
        send_beat(cmd_of(OP_DAA, 8'h99, 8'h00, 16'h0000, 16'h0000, 5'b10000));
        send_beat(cmd_of(OP_DAA, 8'h00, 8'h00, 16'h0000, 16'h0000, 5'b01000));
        send_beat(cmd_of(OP_DAA, 8'h3C, 8'h00, 16'h0000, 16'h0000, 5'b00000));
        send_beat(cmd_of(OP_DAD, 8'h00, 8'h00, 16'hFFFF, 16'h0001, 5'b00000));
        send_beat(cmd_of(OP_DAD, 8'hFF, 8'hFF, 16'h0000, 16'h0000, 5'b10000));
        wait_results();

        idle_on = 1'b1;
        for (int i = 0; i < RandItems; i++)
        begin
            if (i % 64 == 0)
            begin
                idle_on = 1'($urandom_range(0, 1));
            end
            if (i == RandItems / 2)
            begin
                wait_results();
            end
            if (i < RandItems - QuietTail && idle_on && $urandom_range(0, 3) == 0)
            begin
                idle_cycles($urandom_range(1, 6));
            end
            send_beat(random_cmd());
        end

        // drain, then wait and check that no result is still pending
        wait_results();
        repeat (4) @(negedge clk);
        if (sb.pending_results.size() != 0)
        begin
            sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));
        end
        if (sb.mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
